FILE: design/fte_pkg.sv
// ----------------------------------------------------------------------------
// fte_pkg
// Shared types and constants of the Fenwick tree engine: field widths,
// operation codes, sign constant and the flag bundle of the shared adder.
// ----------------------------------------------------------------------------
package fte_pkg;

	// field widths on the channels
	localparam int MODE_W = 3;
	localparam int IDX_W  = 11;
	localparam int VAL_W  = 32;
	localparam int SUM_W  = 64;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_ADD   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RANGE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_LOWER = 3'd4;
	localparam logic [MODE_W-1:0] MODE_UPPER = 3'd5;

	// size register value after reset
	localparam logic [IDX_W-1:0] SIZE_RESET = 11'd1024;

	// sign bit of a 64-bit sum
	localparam logic [SUM_W-1:0] SIGN64 = 64'h8000_0000_0000_0000;

	// status of the shared adder/comparator
	typedef struct packed {
		logic lt; // signed a < b (valid on subtract)
		logic eq; // a == b (valid on subtract)
	} alu_flags_t;

endpackage

FILE: design/fte_req_if.sv
// ----------------------------------------------------------------------------
// fte_req_if
// Request channel of the Fenwick tree engine: valid/ready plus operation.
// ----------------------------------------------------------------------------
interface fte_req_if;
	logic                                valid;
	logic                                ready;
	logic [fte_pkg::MODE_W-1:0]          mode;
	logic [fte_pkg::IDX_W-1:0]           index_a;
	logic [fte_pkg::IDX_W-1:0]           index_b;
	logic signed [fte_pkg::VAL_W-1:0]    operand_value;

	modport source (output valid, mode, index_a, index_b, operand_value, input ready);
	modport sink (input valid, mode, index_a, index_b, operand_value, output ready);
endinterface

FILE: design/fte_rsp_if.sv
// ----------------------------------------------------------------------------
// fte_rsp_if
// Result channel of the Fenwick tree engine: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface fte_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [fte_pkg::SUM_W-1:0]    sum_value;
	logic [fte_pkg::IDX_W-1:0]           found_index;
	logic                                error_flag;

	modport source (output valid, sum_value, found_index, error_flag, input ready);
	modport sink (input valid, sum_value, found_index, error_flag, output ready);
endinterface

FILE: design/fenwick_tree_engine_unit.sv
// ----------------------------------------------------------------------------
// fenwick_tree_engine_unit
// Zero-indexed Fenwick tree over a RAM of 64-bit cells: add, set, range sum,
// point read, lower and upper bound, walked one cell at a time through one
// shared adder/comparator.
//
//   channel  dir  handshake          contents
//   req      in   valid/ready        mode, index_a, index_b, operand_value
//   rsp      out  valid/ready        sum_value, found_index, error_flag
//   cfg      in   cfg_we             cfg_wdata -> size_in_use
//
// Each visited cell is a RAM read, then an add or compare; each walk also
// has an end step, and a request has a step to be accepted and one to post
// its result. After reset the cells are cleared one per cycle while
// req.ready is low. A finished result waits in the output register; the
// next request is taken meanwhile and its result is held until the slot is
// free.
// ----------------------------------------------------------------------------
module fenwick_tree_engine_unit #(
	parameter int CAPACITY = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	fte_req_if.sink                    req,
	fte_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [fte_pkg::IDX_W-1:0]  cfg_wdata
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = (CW > fte_pkg::IDX_W) ? CW : fte_pkg::IDX_W;
	localparam int SW = fte_pkg::SUM_W;

	typedef enum logic [9:0] {
		S_CLEAR   = 10'b00_0000_0001,
		S_IDLE    = 10'b00_0000_0010,
		S_PFX_RD  = 10'b00_0000_0100,
		S_PFX_AC  = 10'b00_0000_1000,
		S_DELTA   = 10'b00_0001_0000,
		S_UPD_RD  = 10'b00_0010_0000,
		S_UPD_WR  = 10'b00_0100_0000,
		S_DSC_RD  = 10'b00_1000_0000,
		S_DSC_CMP = 10'b01_0000_0000,
		S_DONE    = 10'b10_0000_0000
	} state_t;

	state_t                     state_q;
	logic [fte_pkg::IDX_W-1:0]  size_q;
	logic [IW-1:0]              clr_q;
	logic [fte_pkg::MODE_W-1:0] mode_q;
	logic                       err_q;
	logic [CW-1:0]              a_q;
	logic [CW-1:0]              j_q;
	logic [CW-1:0]              k2_q;
	logic                       second_q;
	logic                       sub_q;
	logic [CW-1:0]              i_q;
	logic [CW-1:0]              pos_q;
	logic [CW-1:0]              w_q;
	logic [SW-1:0]              acc_q;
	logic [SW-1:0]              x_q;
	logic                       out_valid_q;
	logic [SW-1:0]              out_sum_q;
	logic [fte_pkg::IDX_W-1:0]  out_found_q;
	logic                       out_err_q;

	logic [LW-1:0]              size_l;
	logic [CW-1:0]              n_eff;
	logic [LW-1:0]              n_l;
	logic [LW-1:0]              a_l;
	logic [LW-1:0]              b_l;
	logic [CW-1:0]              a_cw;
	logic [CW-1:0]              b_cw;
	logic [CW-1:0]              start_pow;
	logic [CW-1:0]              j_m1;
	logic [CW:0]                pos_w;
	logic [CW:0]                pos_w_m1;
	logic                       req_fire;
	logic                       req_err;
	logic                       take;
	logic                       slot_free;

	logic                       ram_we;
	logic [IW-1:0]              ram_waddr;
	logic [SW-1:0]              ram_wdata;
	logic [IW-1:0]              ram_raddr;
	logic [SW-1:0]              ram_rdata;

	logic [SW-1:0]              alu_a;
	logic [SW-1:0]              alu_b;
	logic                       alu_sub;
	logic [SW-1:0]              alu_res;
	fte_pkg::alu_flags_t        alu_flags;

	// element count clamped to [1, CAPACITY]
	always_comb begin
		size_l = LW'(size_q);
		if (size_l == '0) begin
			n_eff = CW'(1);
		end else if (size_l > LW'(CAPACITY)) begin
			n_eff = CW'(CAPACITY);
		end else begin
			n_eff = CW'(size_l);
		end
	end

	// largest power of two not above the element count
	always_comb begin
		start_pow = '0;
		for (int k = 0; k < CW; k++) begin
			if (n_eff[k]) begin
				start_pow = CW'(1) << k;
			end
		end
	end

	// request decode and range checks
	assign n_l      = LW'(n_eff);
	assign a_l      = LW'(req.index_a);
	assign b_l      = LW'(req.index_b);
	assign a_cw     = CW'(a_l);
	assign b_cw     = CW'(b_l);
	assign req_fire = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		unique case (req.mode)
			fte_pkg::MODE_ADD, fte_pkg::MODE_SET, fte_pkg::MODE_READ: begin
				req_err = !(a_l < n_l);
			end
			fte_pkg::MODE_RANGE: begin
				req_err = !((a_l <= b_l) && (b_l <= n_l));
			end
			fte_pkg::MODE_LOWER, fte_pkg::MODE_UPPER: begin
				req_err = !(a_l <= n_l);
			end
			default: begin
				req_err = 1'b1;
			end
		endcase
	end

	// walk address arithmetic
	assign j_m1     = j_q - CW'(1);
	assign pos_w    = {1'b0, pos_q} + {1'b0, w_q};
	assign pos_w_m1 = pos_w - (CW + 1)'(1);

	// descent step: take the cell when the threshold passes it
	assign take = (mode_q == fte_pkg::MODE_UPPER) ? !alu_flags.lt
	                                               : (!alu_flags.lt && !alu_flags.eq);

	assign slot_free = !out_valid_q || rsp.ready;

	// operand selection for the shared adder
	always_comb begin
		alu_a   = acc_q;
		alu_b   = ram_rdata;
		alu_sub = sub_q;
		unique case (state_q)
			S_DELTA: begin
				alu_a   = x_q;
				alu_b   = acc_q;
				alu_sub = 1'b1;
			end
			S_UPD_WR: begin
				alu_a   = ram_rdata;
				alu_b   = x_q;
				alu_sub = 1'b0;
			end
			S_DSC_CMP: begin
				alu_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	fte_alu u_alu (
		.op_a  (alu_a),
		.op_b  (alu_b),
		.sub   (alu_sub),
		.res   (alu_res),
		.flags (alu_flags)
	);

	// memory port selection
	always_comb begin
		ram_we    = (state_q == S_CLEAR) || (state_q == S_UPD_WR);
		ram_waddr = (state_q == S_CLEAR) ? clr_q : i_q[IW-1:0];
		ram_wdata = (state_q == S_CLEAR) ? '0 : alu_res;
		unique case (state_q)
			S_UPD_RD: ram_raddr = i_q[IW-1:0];
			S_DSC_RD: ram_raddr = pos_w_m1[IW-1:0];
			default:  ram_raddr = j_m1[IW-1:0];
		endcase
	end

	fte_ram #(
		.WIDTH (SW),
		.DEPTH (CAPACITY)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= fte_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			size_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			second_q <= 1'b0;
			sub_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == IW'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						sub_q <= 1'b0;
						if (req_err) begin
							state_q <= S_DONE;
						end else begin
							unique case (req.mode)
								fte_pkg::MODE_ADD: begin
									i_q     <= a_cw;
									state_q <= S_UPD_RD;
								end
								fte_pkg::MODE_RANGE: begin
									j_q      <= b_cw;
									k2_q     <= a_cw;
									second_q <= 1'b1;
									acc_q    <= '0;
									state_q  <= S_PFX_RD;
								end
								fte_pkg::MODE_LOWER, fte_pkg::MODE_UPPER: begin
									j_q      <= a_cw;
									second_q <= 1'b0;
									acc_q    <= {{(SW - fte_pkg::VAL_W){req.operand_value[fte_pkg::VAL_W-1]}},
									             req.operand_value};
									state_q  <= S_PFX_RD;
								end
								default: begin
									j_q      <= a_cw + CW'(1);
									k2_q     <= a_cw;
									second_q <= 1'b1;
									acc_q    <= '0;
									state_q  <= S_PFX_RD;
								end
							endcase
						end
					end
				end
				S_PFX_RD: begin
					if (j_q != '0) begin
						state_q <= S_PFX_AC;
					end else if (second_q) begin
						j_q      <= k2_q;
						sub_q    <= 1'b1;
						second_q <= 1'b0;
					end else begin
						unique case (mode_q)
							fte_pkg::MODE_SET: begin
								state_q <= S_DELTA;
							end
							fte_pkg::MODE_LOWER, fte_pkg::MODE_UPPER: begin
								sub_q   <= 1'b1;
								pos_q   <= '0;
								w_q     <= start_pow;
								state_q <= S_DSC_RD;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PFX_AC: begin
					acc_q   <= alu_res;
					j_q     <= j_q & j_m1;
					state_q <= S_PFX_RD;
				end
				S_DELTA: begin
					i_q     <= a_q;
					state_q <= S_UPD_RD;
				end
				S_UPD_RD: begin
					if (i_q >= CW'(CAPACITY)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_UPD_WR;
					end
				end
				S_UPD_WR: begin
					i_q     <= i_q | (i_q + CW'(1));
					state_q <= S_UPD_RD;
				end
				S_DSC_RD: begin
					if (w_q == '0) begin
						state_q <= S_DONE;
					end else if (pos_w <= {1'b0, n_eff}) begin
						state_q <= S_DSC_CMP;
					end else begin
						w_q <= w_q >> 1;
					end
				end
				S_DSC_CMP: begin
					if (take) begin
						acc_q <= alu_res;
						pos_q <= pos_w[CW-1:0];
					end
					w_q     <= w_q >> 1;
					state_q <= S_DSC_RD;
				end
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload, captured on accept; x_q then takes the delta in S_DELTA
	always_ff @(posedge clk) begin
		if (req_fire) begin
			mode_q <= req.mode;
			err_q  <= req_err;
			a_q    <= a_cw;
			x_q    <= {{(SW - fte_pkg::VAL_W){req.operand_value[fte_pkg::VAL_W-1]}},
			           req.operand_value};
		end else if (state_q == S_DELTA) begin
			x_q <= alu_res;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && slot_free) begin
			out_err_q   <= err_q;
			out_sum_q   <= '0;
			out_found_q <= '0;
			if (!err_q) begin
				case (mode_q)
					fte_pkg::MODE_RANGE, fte_pkg::MODE_READ: begin
						out_sum_q <= acc_q;
					end
					fte_pkg::MODE_LOWER, fte_pkg::MODE_UPPER: begin
						out_found_q <= fte_pkg::IDX_W'((pos_q < a_q) ? a_q : pos_q);
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.sum_value   = out_sum_q;
	assign rsp.found_index = out_found_q;
	assign rsp.error_flag  = out_err_q;

endmodule

FILE: design/fte_ram.sv
// ----------------------------------------------------------------------------
// fte_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fte_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/fte_alu.sv
// ----------------------------------------------------------------------------
// fte_alu
// Shared 64-bit add/subtract unit with signed less-than and equality flags.
// ----------------------------------------------------------------------------
module fte_alu (
	input  logic [fte_pkg::SUM_W-1:0] op_a,
	input  logic [fte_pkg::SUM_W-1:0] op_b,
	input  logic                      sub,
	output logic [fte_pkg::SUM_W-1:0] res,
	output fte_pkg::alu_flags_t       flags
);

	logic [fte_pkg::SUM_W:0] a_ext;
	logic [fte_pkg::SUM_W:0] b_ext;
	logic [fte_pkg::SUM_W:0] sum_ext;

	// sign-flipped operands turn the carry into a signed compare
	assign a_ext   = {1'b0, op_a ^ fte_pkg::SIGN64};
	assign b_ext   = {1'b0, op_b ^ fte_pkg::SIGN64} ^ {(fte_pkg::SUM_W + 1){sub}};
	assign sum_ext = a_ext + b_ext + {{fte_pkg::SUM_W{1'b0}}, sub};

	// low bits are a +/- b modulo 2^64 since the flips cancel
	assign res      = sum_ext[fte_pkg::SUM_W-1:0];
	assign flags.lt = sum_ext[fte_pkg::SUM_W];
	assign flags.eq = (sum_ext[fte_pkg::SUM_W-1:0] == '0);

endmodule

FILE: design/fte_checker.sv
// ----------------------------------------------------------------------------
// fte_checker
// Port-level checks of the Fenwick tree engine, bound to the top level.
// ----------------------------------------------------------------------------
module fte_checker (
	input logic       clk,
	input logic       arst_n,
	fte_req_if.sink   req,
	fte_rsp_if.source rsp
);

	// a request is worked on alone: ready drops right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while previous one still in work");

	// a rejected request reports zero sum and zero index
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error_flag |-> rsp.sum_value == '0 && rsp.found_index == '0)
		else $error("rejected request carries nonzero result fields");

	// a bound result and a sum never appear together
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found_index != '0 |-> rsp.sum_value == '0)
		else $error("bound result with nonzero sum");

	// a stalled result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.sum_value)
			&& $stable(rsp.found_index) && $stable(rsp.error_flag))
		else $error("result changed while stalled");

endmodule

bind fenwick_tree_engine_unit fte_checker u_fte_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
